@@ hdl/mm4_pkg.sv @@
// Shared types and constants for the 4x4 matrix multiply core.
// Used by the chain cells, the output stage and the top level; no dependencies.
package mm4_pkg;

  localparam int unsigned MatDim = 4;
  localparam int unsigned ElemW  = 32;
  // Exact sum of four 32x32 products needs two bits above one 64-bit product.
  localparam int unsigned AccW   = 2 * ElemW + 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MUL  = 1'b1;

  typedef logic signed [ElemW-1:0]   elem_t;
  typedef logic signed [2*ElemW-1:0] prod_t;
  typedef logic signed [AccW-1:0]    acc_t;

  typedef struct packed {
    logic       func;
    logic [1:0] row_index;
    elem_t      elem_0;
    elem_t      elem_1;
    elem_t      elem_2;
    elem_t      elem_3;
  } in_t;

  typedef struct packed {
    logic [1:0] out_row;
    elem_t      prod_0;
    elem_t      prod_1;
    elem_t      prod_2;
    elem_t      prod_3;
    logic       saturated;
  } out_t;

  // One beat travelling down the chain: loads and multiplies keep their order.
  typedef struct packed {
    logic                    valid;
    logic                    func;
    logic [1:0]              row;
    elem_t [MatDim-1:0]      elems;
    acc_t  [MatDim-1:0]      psum;
  } beat_t;

endpackage

@@ hdl/mm4_cell.sv @@
// One chain cell: holds one row of the right-hand matrix and adds its four products.
// Depends on mm4_pkg.
module mm4_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  mm4_pkg::beat_t beat_i,
  output mm4_pkg::beat_t beat_o
);
  import mm4_pkg::*;

  localparam logic [1:0] CellRow = 2'(CELL_IDX);

  elem_t [MatDim-1:0] w_q;
  beat_t              s1_q;
  logic               s1_valid_q;
  prod_t              prod_q [MatDim];
  prod_t              prod_d [MatDim];
  beat_t              o_q;
  beat_t              o_d;
  logic               o_valid_q;
  elem_t              mul_elem;

  assign mul_elem = beat_i.elems[CellRow];

  // A load for this row updates the weights in stream order, so a multiply
  // that follows it in the chain always sees the new row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (en_i && beat_i.valid && beat_i.func == FUNC_LOAD
                 && beat_i.row == CellRow) begin
      w_q <= beat_i.elems;
    end
  end

  always_comb begin
    for (int j = 0; j < MatDim; j++) begin
      prod_d[j] = mul_elem * w_q[j];
    end
  end

  always_comb begin
    o_d = s1_q;
    for (int j = 0; j < MatDim; j++) begin
      o_d.psum[j] = s1_q.psum[j] + AccW'(prod_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= beat_i.valid;
      o_valid_q  <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= beat_i;
      o_q  <= o_d;
      for (int j = 0; j < MatDim; j++) begin
        prod_q[j] <= prod_d[j];
      end
    end
  end

  always_comb begin
    beat_o       = o_q;
    beat_o.valid = o_valid_q;
  end

endmodule

@@ hdl/mm4_out.sv @@
// Output stage: fixed-point shift, saturation and the result register.
// Depends on mm4_pkg.
module mm4_out #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mm4_pkg::beat_t beat_i,
  output logic           advance_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mm4_pkg::out_t  out_data_o
);
  import mm4_pkg::*;

  acc_t              shifted [MatDim];
  elem_t [MatDim-1:0] res;
  logic [MatDim-1:0] clip;
  logic              is_mul;
  logic              take;
  logic              out_valid_q;
  out_t              out_q;
  out_t              out_d;

  assign is_mul = beat_i.valid && beat_i.func == FUNC_MUL;

  // The chain only stalls when a product row reaches the end while the
  // result register still holds a beat nobody has taken.
  assign advance_o = !(out_valid_q && !out_ready_i && is_mul);
  assign take      = advance_o && is_mul;

  always_comb begin
    for (int j = 0; j < MatDim; j++) begin
      shifted[j] = $signed(beat_i.psum[j]) >>> FRAC_BITS;
      if (!shifted[j][AccW-1] && |shifted[j][AccW-2:ElemW-1]) begin
        res[j]  = {1'b0, {(ElemW-1){1'b1}}};
        clip[j] = 1'b1;
      end else if (shifted[j][AccW-1] && !(&shifted[j][AccW-2:ElemW-1])) begin
        res[j]  = {1'b1, {(ElemW-1){1'b0}}};
        clip[j] = 1'b1;
      end else begin
        res[j]  = shifted[j][ElemW-1:0];
        clip[j] = 1'b0;
      end
    end
    out_d.out_row   = beat_i.row;
    out_d.prod_0    = res[0];
    out_d.prod_1    = res[1];
    out_d.prod_2    = res[2];
    out_d.prod_3    = res[3];
    out_d.saturated = |clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/matrix_multiply_4x4_core.sv @@
// 4x4 matrix multiply core, signed Q16.16, one row per beat.
// A multiply beat's product row passes two register stages in each of four chain cells, the first
// loaded at the accepting edge, and then the result register.
// Throughput: one beat per cycle; a stall only arises when a product row meets a held result.
// Reset is asynchronous and active low; it clears the stored right-hand matrix to zero.
// Depends on mm4_pkg, mm4_cell and mm4_out.
module matrix_multiply_4x4_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mm4_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mm4_pkg::out_t out_data_o
);
  import mm4_pkg::*;

  beat_t chain [MatDim+1];
  logic  advance;

  always_comb begin
    chain[0].valid    = in_valid_i;
    chain[0].func     = in_data_i.func;
    chain[0].row      = in_data_i.row_index;
    chain[0].elems[0] = in_data_i.elem_0;
    chain[0].elems[1] = in_data_i.elem_1;
    chain[0].elems[2] = in_data_i.elem_2;
    chain[0].elems[3] = in_data_i.elem_3;
    chain[0].psum     = '0;
  end

  for (genvar k = 0; k < MatDim; k++) begin : g_cell
    mm4_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .beat_i (chain[k]),
      .beat_o (chain[k+1])
    );
  end

  mm4_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (chain[MatDim]),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign in_ready_o = advance;

`ifndef ASSERT_OFF
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("chain stalled without a blocked result");

  a_row_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && chain[MatDim].valid && chain[MatDim].func == FUNC_MUL |=> out_valid_o)
    else $error("product row left the chain without reaching the output");

  a_sat_flag_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.prod_0 == {1'b0, {(ElemW-1){1'b1}}} ||
      out_data_o.prod_0 == {1'b1, {(ElemW-1){1'b0}}} ||
      out_data_o.prod_1 == {1'b0, {(ElemW-1){1'b1}}} ||
      out_data_o.prod_1 == {1'b1, {(ElemW-1){1'b0}}} ||
      out_data_o.prod_2 == {1'b0, {(ElemW-1){1'b1}}} ||
      out_data_o.prod_2 == {1'b1, {(ElemW-1){1'b0}}} ||
      out_data_o.prod_3 == {1'b0, {(ElemW-1){1'b1}}} ||
      out_data_o.prod_3 == {1'b1, {(ElemW-1){1'b0}}})
    else $error("saturated flag set with no clipped element");
`endif

endmodule

@@ tb/matrix_multiply_4x4_core_tb.sv @@
// Self-checking testbench for the 4x4 Q16.16 matrix multiply core.
// Drives load and multiply rows, predicts each product row and checks it beat by beat.
// Depends on mm4_pkg and matrix_multiply_4x4_core.
`timescale 1ns / 100ps

module matrix_multiply_4x4_core_tb;
  import mm4_pkg::*;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned NumRandom = 1320;
  // Leave margin after the last expected product row for stray outputs.
  localparam int unsigned DrainCycles = 40;

  localparam elem_t E_MAX   = 32'sh7FFF_FFFF;
  localparam elem_t E_MIN   = 32'sh8000_0000;
  localparam elem_t FIX_ONE = 32'sh0001_0000;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  in_t   in_data_i   = '0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  out_t  out_data_o;

  in_t   pend_rows_q [$];
  out_t  prod_rows_q [$];
  elem_t right_m [4][4];

  int unsigned n_loads    = 0;
  int unsigned n_mults    = 0;
  int unsigned n_sat_rows = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errs     = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic [31:0] ready_pat  = '1;
  int unsigned pat_left   = 0;
  out_t        want_row;

  matrix_multiply_4x4_core #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Updates the stored right-hand matrix, or works out the product row of a multiply beat.
  function automatic void apply_row_beat(in_t it);
    elem_t              lrow [4];
    elem_t              col [4];
    logic signed [63:0] prod;
    logic signed [65:0] acc;
    logic signed [65:0] lim_hi;
    logic signed [65:0] lim_lo;
    out_t               res;
    lrow[0] = it.elem_0;
    lrow[1] = it.elem_1;
    lrow[2] = it.elem_2;
    lrow[3] = it.elem_3;
    if (it.func == FUNC_LOAD) begin
      for (int c = 0; c < 4; c++) right_m[it.row_index][c] = lrow[c];
      n_loads++;
    end else begin
      lim_hi = 66'sh7FFF_FFFF;
      lim_lo = -lim_hi - 66'sd1;
      res = '0;
      res.out_row = it.row_index;
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          prod = lrow[k] * right_m[k][j];
          acc = acc + prod;
        end
        // Arithmetic shift floors, so negative sums round toward minus infinity.
        acc = acc >>> FracBits;
        if (acc > lim_hi) begin
          acc = lim_hi;
          res.saturated = 1'b1;
        end else if (acc < lim_lo) begin
          acc = lim_lo;
          res.saturated = 1'b1;
        end
        col[j] = acc[31:0];
      end
      res.prod_0 = col[0];
      res.prod_1 = col[1];
      res.prod_2 = col[2];
      res.prod_3 = col[3];
      prod_rows_q.push_back(res);
      n_mults++;
      if (res.saturated) n_sat_rows++;
    end
  endfunction

  function automatic void push_row(logic func, logic [1:0] row,
                                   elem_t e0, elem_t e1, elem_t e2, elem_t e3);
    in_t it;
    it.func      = func;
    it.row_index = row;
    it.elem_0    = e0;
    it.elem_1    = e1;
    it.elem_2    = e2;
    it.elem_3    = e3;
    pend_rows_q.push_back(it);
  endfunction

  // Value classes: full range, small, near the saturation boundary, and extremes.
  function automatic elem_t pick_elem(int unsigned mode);
    elem_t v;
    case (mode)
      0: v = $urandom;
      1: v = int'($urandom_range(0, 524287)) - 262144;
      2: v = int'($urandom_range(0, 33554431)) - 16777216;
      default: begin
        case ($urandom_range(0, 5))
          0: v = E_MAX;
          1: v = E_MIN;
          2: v = '0;
          3: v = 32'sd1;
          4: v = -32'sd1;
          default: v = FIX_ONE;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic void push_random_row(logic func, int unsigned mode);
    int unsigned m [4];
    for (int i = 0; i < 4; i++) m[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : mode;
    push_row(func, 2'($urandom_range(0, 3)),
             pick_elem(m[0]), pick_elem(m[1]), pick_elem(m[2]), pick_elem(m[3]));
  endfunction

  function automatic void make_directed();
    // The matrix is all zero out of reset.
    push_row(FUNC_MUL, 2'd0, E_MAX, E_MIN, E_MAX, E_MIN);
    // Identity: a product row equals its left row, extremes included.
    for (int r = 0; r < 4; r++)
      push_row(FUNC_LOAD, 2'(r), (r == 0) ? FIX_ONE : '0, (r == 1) ? FIX_ONE : '0,
               (r == 2) ? FIX_ONE : '0, (r == 3) ? FIX_ONE : '0);
    push_row(FUNC_MUL, 2'd1, E_MAX, E_MIN, -32'sd1, 32'sd1);
    push_row(FUNC_MUL, 2'd2, 32'sh1234_5678, 32'sh8765_4321, '0, 32'sh0FED_CBA9);
    // Largest positive matrix: clipping high and low.
    for (int r = 0; r < 4; r++) push_row(FUNC_LOAD, 2'(r), E_MAX, E_MAX, E_MAX, E_MAX);
    push_row(FUNC_MUL, 2'd3, E_MAX, E_MAX, E_MAX, E_MAX);
    push_row(FUNC_MUL, 2'd0, E_MIN, E_MIN, E_MIN, E_MIN);
    // Most negative matrix: four min*min products need the full accumulator width.
    for (int r = 0; r < 4; r++) push_row(FUNC_LOAD, 2'(r), E_MIN, E_MIN, E_MIN, E_MIN);
    push_row(FUNC_MUL, 2'd1, E_MIN, E_MIN, E_MIN, E_MIN);
    push_row(FUNC_MUL, 2'd2, E_MAX, E_MAX, E_MAX, E_MAX);
    // Floor rounding of small negative and positive sums, and a row whose large products cancel.
    push_row(FUNC_LOAD, 2'd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
    push_row(FUNC_LOAD, 2'd1, '0, '0, '0, '0);
    push_row(FUNC_MUL, 2'd3, -32'sd1, '0, '0, '0);
    push_row(FUNC_MUL, 2'd0, 32'sd1, '0, '0, '0);
    push_row(FUNC_MUL, 2'd1, -32'sd65536, '0, E_MAX, E_MIN);
  endfunction

  function automatic void make_random();
    int unsigned n_gen;
    int unsigned n_ld;
    int unsigned n_ml;
    int unsigned mode;
    n_gen = 0;
    while (n_gen < NumRandom) begin
      if ($urandom_range(0, 99) < 85) begin
        // Load up to four rows, then multiply one to six rows against the current matrix.
        mode = $urandom_range(0, 3);
        n_ld = $urandom_range(0, 4);
        n_ml = $urandom_range(1, 6);
        for (int i = 0; i < n_ld; i++) push_random_row(FUNC_LOAD, mode);
        for (int i = 0; i < n_ml; i++) push_random_row(FUNC_MUL, mode);
        n_gen += n_ld + n_ml;
      end else begin
        push_random_row(1'($urandom_range(0, 1)), 0);
        n_gen++;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errs++;
    end
  endfunction

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) apply_row_beat(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pend_rows_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pend_rows_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating ready pattern, replaced by a freshly drawn one when its run ends.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = '1;
          1: ready_pat = $urandom;
          2: ready_pat = $urandom & $urandom;
          default: ready_pat = $urandom | $urandom;
        endcase
        pat_left = $urandom_range(16, 96);
      end else begin
        pat_left--;
      end
      ready_pat = {ready_pat[0], ready_pat[31:1]};
      out_ready_i <= ready_pat[0];
    end
  end

  // Monitor: every accepted product row is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (prod_rows_q.size() == 0) begin
        $display("%0t: unexpected product row, expected none, actual %h", $time, out_data_o);
        n_errs++;
      end else begin
        want_row = prod_rows_q.pop_front();
        check_field("out_row", 32'(want_row.out_row), 32'(out_data_o.out_row));
        check_field("prod_0", want_row.prod_0, out_data_o.prod_0);
        check_field("prod_1", want_row.prod_1, out_data_o.prod_1);
        check_field("prod_2", want_row.prod_2, out_data_o.prod_2);
        check_field("prod_3", want_row.prod_3, out_data_o.prod_3);
        check_field("saturated", 32'(want_row.saturated), 32'(out_data_o.saturated));
        n_checked++;
      end
    end
  end

  initial begin
    foreach (right_m[r, c]) right_m[r][c] = '0;
    make_directed();
    make_random();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pend_rows_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (prod_rows_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d row loads and %0d row multiplies; %0d product rows checked.",
             n_loads, n_mults, n_checked);
    $display("%0d of the product rows were clipped.", n_sat_rows);
    if (n_errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d product rows outstanding.", prod_rows_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mm4_pkg.sv
hdl/mm4_cell.sv
hdl/mm4_out.sv
hdl/matrix_multiply_4x4_core.sv
tb/matrix_multiply_4x4_core_tb.sv
